// ===== hw/rtl/wgm_pkg.sv =====
`timescale 1ns / 1ps

package wgm_pkg;

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_LOAD_HARD = 2'd0,
    OP_LOAD_TYPE = 2'd1,
    OP_LOAD_ELEM = 2'd2,
    OP_COMPUTE   = 2'd3
  } op_t;

  // Register select taken from paddr[2]
  localparam logic REG_ATOM_COUNT = 1'b0;
  localparam logic REG_BOND_COUNT = 1'b1;

  // Q8.24 fixed point
  localparam int Q_SHIFT = 24;
  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;

  // Controller to datapath commands
  typedef struct packed {
    logic issue;    // one multiply-accumulate step enters the pipe
    logic clear;    // start of a new column: zero accumulator and flag
    logic wr_hard;  // write hardness table
    logic wr_type;  // write bond type
    logic wr_elem;  // write matrix element
  } wgm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic busy;     // steps still in flight
  } wgm_sts_t;

endpackage

// ===== hw/rtl/wgm_datapath.sv =====
`timescale 1ns / 1ps

module wgm_datapath import wgm_pkg::*; #(
  parameter int MAX_ATOMS = 64,
  parameter int MAX_BONDS = 128,
  parameter int MAX_TYPES = 32,
  parameter int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1,
  parameter int BW = (MAX_BONDS > 1) ? $clog2(MAX_BONDS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  wgm_cmd_t            cmd,
  output wgm_sts_t            sts,
  // step addressing
  input  logic [BW-1:0]       step_bond,
  input  logic [AW-1:0]       row,
  input  logic [AW-1:0]       col,
  // load payload
  input  logic [6:0]          major_index,
  input  logic [5:0]          minor_index,
  input  logic [4:0]          type_code,
  input  logic signed [31:0]  data_value,
  // column result
  output logic signed [31:0]  element_value,
  output logic                saturated
);

  localparam int TW = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam int MD = MAX_BONDS * (1 << AW);

  // Memories
  logic signed [31:0] hard_mem [MAX_TYPES];
  logic [4:0]         type_mem [MAX_BONDS];
  logic signed [31:0] mat_mem  [MD];

  // Load address decode
  logic [8:0]  hard_ext;
  logic [10:0] bond_ext;
  logic        hard_ok;
  logic        bond_ok;
  logic        atom_ok;

  assign hard_ext = 9'(major_index);
  assign bond_ext = 11'(major_index);
  assign hard_ok  = hard_ext < 9'(MAX_TYPES);
  assign bond_ok  = bond_ext < 11'(MAX_BONDS);
  assign atom_ok  = 7'(minor_index) < 7'(MAX_ATOMS);

  always_ff @(posedge clk) begin
    if (cmd.wr_hard && hard_ok) begin
      hard_mem[hard_ext[TW-1:0]] <= data_value;
    end
    if (cmd.wr_type && bond_ok) begin
      type_mem[bond_ext[BW-1:0]] <= type_code;
    end
    if (cmd.wr_elem && bond_ok && atom_ok) begin
      mat_mem[{bond_ext[BW-1:0], minor_index[AW-1:0]}] <= data_value;
    end
  end

  // Pipeline registers
  logic               v1, v2, v3, v4, v5;
  logic [4:0]         type1;
  logic signed [31:0] pi1, pj1, pi2, pj2, pj3, pj4;
  logic signed [31:0] hrd2;
  logic               hv2;
  logic signed [63:0] p1, p2;
  logic signed [31:0] w4;
  logic               ws4, ws5;
  logic signed [63:0] acc;
  logic               acc_sat;

  logic [8:0]         type_ext;
  logic               type_ok;
  logic signed [63:0] p1_shift;
  logic signed [63:0] p2_shift;
  logic signed [31:0] w_clip;
  logic               w_sat;

  assign type_ext = 9'(type1);
  assign type_ok  = type_ext < 9'(MAX_TYPES);
  assign p1_shift = p1 >>> Q_SHIFT;
  assign p2_shift = p2 >>> Q_SHIFT;

  // Weight clip to 32 bits
  always_comb begin
    w_sat  = 1'b0;
    w_clip = p1_shift[31:0];
    if (p1_shift > S32_MAX) begin
      w_sat  = 1'b1;
      w_clip = S32_MAX[31:0];
    end else if (p1_shift < S32_MIN) begin
      w_sat  = 1'b1;
      w_clip = S32_MIN[31:0];
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    // stage 1: bond type and both matrix words
    type1 <= type_mem[step_bond];
    pi1   <= mat_mem[{step_bond, row}];
    pj1   <= mat_mem[{step_bond, col}];
    // stage 2: hardness lookup
    hrd2  <= hard_mem[type_ext[TW-1:0]];
    hv2   <= type_ok;
    pi2   <= pi1;
    pj2   <= pj1;
    // stage 3: P[k][i] * h, 32 by 32 signed
    p1    <= 64'(pi2) * 64'(hv2 ? hrd2 : 32'sd0);
    pj3   <= pj2;
    // stage 4: scale and clip weight
    w4    <= w_clip;
    ws4   <= w_sat;
    pj4   <= pj3;
    // stage 5: w * P[k][j], 32 by 32 signed
    p2    <= 64'(w4) * 64'(pj4);
    ws5   <= ws4;
  end

  // Valid chain and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      acc <= '0;
      acc_sat <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      if (cmd.clear) begin
        acc     <= '0;
        acc_sat <= 1'b0;
      end else if (v5) begin
        acc     <= acc + p2_shift;
        acc_sat <= acc_sat | ws5;
      end
    end
  end

  assign sts.busy = v1 | v2 | v3 | v4 | v5;

  // Final clip, stable while the accumulator rests
  always_comb begin
    saturated     = acc_sat;
    element_value = acc[31:0];
    if (acc > S32_MAX) begin
      saturated     = 1'b1;
      element_value = S32_MAX[31:0];
    end else if (acc < S32_MIN) begin
      saturated     = 1'b1;
      element_value = S32_MIN[31:0];
    end
  end

endmodule

// ===== hw/rtl/wgm_ctrl.sv =====
`timescale 1ns / 1ps

module wgm_ctrl import wgm_pkg::*; #(
  parameter int MAX_ATOMS = 64,
  parameter int MAX_BONDS = 128,
  parameter int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1,
  parameter int BW = (MAX_BONDS > 1) ? $clog2(MAX_BONDS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [6:0]    atom_count,
  input  logic [7:0]    bond_count,
  // request side
  input  logic          req_valid,
  output logic          req_ready,
  input  op_t           op,
  input  logic [6:0]    major_index,
  // result side
  output logic          res_valid,
  input  logic          res_ready,
  output logic          res_last,
  // datapath
  output wgm_cmd_t      cmd,
  input  wgm_sts_t      sts,
  output logic [BW-1:0] step_bond,
  output logic [AW-1:0] row,
  output logic [AW-1:0] col
);

  localparam int NBW = $clog2(MAX_BONDS + 1);
  localparam int CW  = (NBW > 8) ? NBW : 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_OUT
  } state_t;

  state_t state;
  logic   issue;
  logic   clear;

  // Effective counts
  logic [6:0]     n_atoms;
  logic [CW-1:0]  bc_ext;
  logic [NBW-1:0] n_bonds;
  logic [NBW-1:0] last_bond;
  logic           row_ok;
  logic           accept;

  assign n_atoms   = (atom_count < 7'(MAX_ATOMS)) ? atom_count : 7'(MAX_ATOMS);
  assign bc_ext    = CW'(bond_count);
  assign n_bonds   = (bc_ext < CW'(MAX_BONDS)) ? NBW'(bc_ext) : NBW'(MAX_BONDS);
  assign last_bond = n_bonds - NBW'(1);
  assign row_ok    = major_index < n_atoms;
  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign res_last  = (7'(col) + 7'd1) == n_atoms;

  // Load strobes go straight to the memories
  assign cmd.issue   = issue;
  assign cmd.clear   = clear;
  assign cmd.wr_hard = accept && (op == OP_LOAD_HARD);
  assign cmd.wr_type = accept && (op == OP_LOAD_TYPE);
  assign cmd.wr_elem = accept && (op == OP_LOAD_ELEM);

  // Sequencer: bonds inner, columns outer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issue     <= 1'b0;
      clear     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          clear <= 1'b0;
          if (accept && (op == OP_COMPUTE) && row_ok) begin
            row       <= major_index[AW-1:0];
            col       <= '0;
            step_bond <= '0;
            clear     <= 1'b1;
            if (n_bonds == '0) begin
              state <= S_DRAIN;
            end else begin
              issue <= 1'b1;
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          clear <= 1'b0;
          if (NBW'(step_bond) == last_bond) begin
            issue <= 1'b0;
            state <= S_DRAIN;
          end else begin
            step_bond <= step_bond + BW'(1);
          end
        end
        S_DRAIN: begin
          clear <= 1'b0;
          if (!sts.busy) begin
            res_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            if (res_last) begin
              state <= S_IDLE;
            end else begin
              col       <= col + AW'(1);
              step_bond <= '0;
              clear     <= 1'b1;
              if (n_bonds == '0) begin
                state <= S_DRAIN;
              end else begin
                issue <= 1'b1;
                state <= S_RUN;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // New requests only with an empty pipe
  assert property (@(posedge clk) disable iff (rst) req_ready |-> !sts.busy && !issue)
    else $error("request taken while steps in flight");

  // A result is shown only after the pipe has drained
  assert property (@(posedge clk) disable iff (rst) res_valid |-> !sts.busy && !issue)
    else $error("result shown before accumulation finished");

  // Row and column of a shown result lie inside the matrix
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (7'(row) < n_atoms) && (7'(col) < n_atoms))
    else $error("result index out of range");

  // Accumulator restarts at every column
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && !res_last) |=> clear)
    else $error("next column started without clearing");

endmodule

// ===== hw/rtl/weighted_gram_matrix_engine.sv =====
`timescale 1ns / 1ps

// Weighted Gram matrix engine: H = P^T diag(h) P in signed Q8.24. Load
// requests (hardness per type, type per bond, element of P) go straight
// into the stores. A compute request for row i walks, for each column j,
// all bonds through one six-stage multiply-accumulate pipeline that reads
// two matrix words per cycle, then drains it and presents H[i][j]; the
// next column starts once the result is taken. Requests are taken only
// between rows. Stores are not cleared after reset: every entry must be
// loaded before a compute reads it. Registers: atom_count at 0x0,
// bond_count at 0x4.
module weighted_gram_matrix_engine import wgm_pkg::*; #(
  parameter int MAX_ATOMS = 64,
  parameter int MAX_BONDS = 128,
  parameter int MAX_TYPES = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // major_index, minor_index, type_code, data_value
  input  logic [1:0]  s_tuser,  // operation
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // row_index, column_index, element_value
  output logic        m_tuser,  // saturated
  output logic        m_tlast   // last_of_row
);

  localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int BW = (MAX_BONDS > 1) ? $clog2(MAX_BONDS) : 1;

  // Configuration registers
  logic [6:0] atom_count;
  logic [7:0] bond_count;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      atom_count <= 7'd2;
      bond_count <= 8'd1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_BOND_COUNT) begin
        bond_count <= pwdata[7:0];
      end else begin
        atom_count <= pwdata[6:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_BOND_COUNT) ? 32'(bond_count) : 32'(atom_count);

  // Request fields
  op_t                op;
  logic [6:0]         major_index;
  logic [5:0]         minor_index;
  logic [4:0]         type_code;
  logic signed [31:0] data_value;

  assign op          = op_t'(s_tuser);
  assign major_index = s_tdata[6:0];
  assign minor_index = s_tdata[12:7];
  assign type_code   = s_tdata[17:13];
  assign data_value  = s_tdata[49:18];

  wgm_cmd_t           cmd;
  wgm_sts_t           sts;
  logic [BW-1:0]      step_bond;
  logic [AW-1:0]      row;
  logic [AW-1:0]      col;
  logic signed [31:0] element_value;
  logic               saturated;

  wgm_ctrl #(
    .MAX_ATOMS (MAX_ATOMS),
    .MAX_BONDS (MAX_BONDS),
    .AW        (AW),
    .BW        (BW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .atom_count  (atom_count),
    .bond_count  (bond_count),
    .req_valid   (s_tvalid),
    .req_ready   (s_tready),
    .op          (op),
    .major_index (major_index),
    .res_valid   (m_tvalid),
    .res_ready   (m_tready),
    .res_last    (m_tlast),
    .cmd         (cmd),
    .sts         (sts),
    .step_bond   (step_bond),
    .row         (row),
    .col         (col)
  );

  wgm_datapath #(
    .MAX_ATOMS (MAX_ATOMS),
    .MAX_BONDS (MAX_BONDS),
    .MAX_TYPES (MAX_TYPES),
    .AW        (AW),
    .BW        (BW)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .step_bond     (step_bond),
    .row           (row),
    .col           (col),
    .major_index   (major_index),
    .minor_index   (minor_index),
    .type_code     (type_code),
    .data_value    (data_value),
    .element_value (element_value),
    .saturated     (saturated)
  );

  // Result packing
  assign m_tdata = {4'b0, element_value, 6'(col), 6'(row)};
  assign m_tuser = saturated;

endmodule

// ===== bench/weighted_gram_matrix_engine_tb.sv =====
`timescale 1ns / 1ps

module weighted_gram_matrix_engine_tb;
  import wgm_pkg::*;

  localparam int ATOMS_MAX = 64;
  localparam int BONDS_MAX = 128;
  localparam int KINDS_MAX = 32;
  localparam int FRAC_BITS = 24;
  localparam int DRAIN_CYCLES = 16;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam logic signed [63:0] TOP32 = 64'sd2147483647;
  localparam logic signed [63:0] BOT32 = -64'sd2147483648;
  localparam logic [31:0] Q_ONE = 32'h0100_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hFF00_0000;
  localparam logic [31:0] Q_SIXTY_FOUR = 32'h4000_0000;
  localparam logic [31:0] Q_NEG_SIXTY_FOUR = 32'hC000_0000;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;  // major_index, minor_index, type_code, data_value
  logic [1:0]  s_tuser = '0;  // operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;       // row_index, column_index, element_value
  logic        m_tuser;       // saturated
  logic        m_tlast;       // last_of_row

  weighted_gram_matrix_engine dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One element of H as the block should emit it
  typedef struct {
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] value;
    logic        sat;
    logic        last;
  } gram_elem_t;

  gram_elem_t expected_elems[$];

  // Mirror of the block's stores and registers, with written marks
  logic signed [31:0] hard_mem [KINDS_MAX];
  logic [4:0]         bond_kind [BONDS_MAX];
  logic signed [31:0] p_mem [BONDS_MAX * ATOMS_MAX];
  bit                 hard_set [KINDS_MAX];
  bit                 kind_set [BONDS_MAX];
  bit                 p_set [BONDS_MAX * ATOMS_MAX];
  logic [6:0]         atoms_reg = 7'd2;
  logic [7:0]         bonds_reg = 8'd1;

  int     mismatches = 0;
  longint cycle_count = 0;
  int     send_burst = 0;
  int     ready_burst = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches < 200) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic int used_atoms();
    return (atoms_reg < ATOMS_MAX) ? int'(atoms_reg) : ATOMS_MAX;
  endfunction

  function automatic int used_bonds();
    return (bonds_reg < BONDS_MAX) ? int'(bonds_reg) : BONDS_MAX;
  endfunction

  // Q8.24 values: mostly within +-2.0, some extremes and raw words
  function automatic logic [31:0] draw_q();
    case ($urandom_range(0, 9))
      0: return Q_MIN;
      1: return Q_MAX;
      2, 3: return $urandom();
      default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    endcase
  endfunction

  // Index mostly below the used count, sometimes anywhere in the field
  function automatic int pick_index(input int limit, input int field_max);
    if (limit > 0 && $urandom_range(0, 3) != 0) return $urandom_range(0, limit - 1);
    return $urandom_range(0, field_max);
  endfunction

  // Row i of P^T diag(h) P: weight clipped per term, sum clipped at the end
  function automatic void predict_row(input logic [6:0] row);
    logic signed [63:0] pi, pj, h, w, acc;
    logic sat;
    gram_elem_t e;
    int n, nb;
    n = used_atoms();
    nb = used_bonds();
    if (row >= n) return;
    for (int j = 0; j < n; j++) begin
      acc = '0;
      sat = 1'b0;
      for (int k = 0; k < nb; k++) begin
        h = hard_mem[bond_kind[k]];
        pi = p_mem[k * ATOMS_MAX + row];
        pj = p_mem[k * ATOMS_MAX + j];
        w = (pi * h) >>> FRAC_BITS;
        if (w > TOP32) begin
          w = TOP32;
          sat = 1'b1;
        end else if (w < BOT32) begin
          w = BOT32;
          sat = 1'b1;
        end
        acc = acc + ((w * pj) >>> FRAC_BITS);
      end
      if (acc > TOP32) begin
        acc = TOP32;
        sat = 1'b1;
      end else if (acc < BOT32) begin
        acc = BOT32;
        sat = 1'b1;
      end
      e.row = row[5:0];
      e.col = 6'(j);
      e.value = acc[31:0];
      e.sat = sat;
      e.last = (j == n - 1);
      expected_elems.push_back(e);
    end
  endfunction

  // Apply one accepted request to the mirror
  function automatic void apply_request(input op_t op, input logic [6:0] major,
                                        input logic [5:0] minor, input logic [4:0] tcode,
                                        input logic [31:0] data);
    case (op)
      OP_LOAD_HARD: begin
        // type index past the table is dropped
        if (major < KINDS_MAX) begin
          hard_mem[major] = data;
          hard_set[major] = 1'b1;
        end
      end
      OP_LOAD_TYPE: begin
        bond_kind[major] = tcode;
        kind_set[major] = 1'b1;
      end
      OP_LOAD_ELEM: begin
        p_mem[major * ATOMS_MAX + minor] = data;
        p_set[major * ATOMS_MAX + minor] = 1'b1;
      end
      default: predict_row(major);
    endcase
  endfunction

  // Send one request; valid stays high afterwards until the next gap or settle
  task automatic send_request(input op_t op, input logic [6:0] major, input logic [5:0] minor,
                              input logic [4:0] tcode, input logic [31:0] data);
    int gap;
    if (send_burst > 0) begin
      gap = 0;
      send_burst--;
    end else begin
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 40) == 0) send_burst = $urandom_range(8, 24);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {6'b0, data, tcode, minor, major};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_request(op, major, minor, tcode, data);
  endtask

  // Drop valid, wait for every expected element, then let the block drain
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_elems.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write while idle, followed by a read back
  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    logic [31:0] got, want;
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_sel == REG_ATOM_COUNT) begin
      atoms_reg = value[6:0];
      want = {25'b0, value[6:0]};
    end else begin
      bonds_reg = value[7:0];
      want = {24'b0, value[7:0]};
    end
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== want)
      report_mismatch($sformatf("register %0d reads %h, wrote %h", reg_sel, got, want));
  endtask

  // Load every entry a compute can read under the current counts
  task automatic fill_missing();
    int n, nb;
    n = used_atoms();
    nb = used_bonds();
    for (int k = 0; k < nb; k++) begin
      if (!kind_set[k])
        send_request(OP_LOAD_TYPE, 7'(k), 6'($urandom()), 5'($urandom()), $urandom());
      if (!hard_set[bond_kind[k]])
        send_request(OP_LOAD_HARD, 7'(bond_kind[k]), 6'($urandom()), 5'($urandom()), draw_q());
      for (int i = 0; i < n; i++)
        if (!p_set[k * ATOMS_MAX + i])
          send_request(OP_LOAD_ELEM, 7'(k), 6'(i), 5'($urandom()), draw_q());
    end
  endtask

  task automatic compute_row(input logic [6:0] row);
    fill_missing();
    send_request(OP_COMPUTE, row, 6'($urandom()), 5'($urandom()), $urandom());
  endtask

  // Field extremes and dropped loads under the reset counts
  task automatic test_loads_at_reset();
    send_request(OP_LOAD_HARD, 7'd0, 6'd63, 5'd31, Q_ONE);
    send_request(OP_LOAD_HARD, 7'd31, 6'd0, 5'd0, Q_MAX);
    // past the table: must not alias onto type 0
    send_request(OP_LOAD_HARD, 7'd32, 6'd0, 5'd0, Q_MIN);
    send_request(OP_LOAD_HARD, 7'd127, 6'd63, 5'd31, Q_MIN);
    send_request(OP_LOAD_TYPE, 7'd0, 6'd63, 5'd0, Q_MAX);
    send_request(OP_LOAD_TYPE, 7'd127, 6'd0, 5'd31, '0);
    send_request(OP_LOAD_ELEM, 7'd0, 6'd0, 5'd31, Q_ONE);
    send_request(OP_LOAD_ELEM, 7'd0, 6'd1, 5'd0, Q_NEG_ONE);
    send_request(OP_LOAD_ELEM, 7'd127, 6'd63, 5'd31, Q_MIN);
    compute_row(7'd0);
    compute_row(7'd2);
    compute_row(7'd127);
  endtask

  // Final clip alone, then weight clip as well
  task automatic test_clipping();
    send_request(OP_LOAD_TYPE, 7'd1, 6'd0, 5'd0, '0);
    send_request(OP_LOAD_TYPE, 7'd2, 6'd0, 5'd31, '0);
    send_request(OP_LOAD_ELEM, 7'd1, 6'd0, 5'd0, Q_SIXTY_FOUR);
    send_request(OP_LOAD_ELEM, 7'd1, 6'd1, 5'd0, Q_NEG_SIXTY_FOUR);
    send_request(OP_LOAD_ELEM, 7'd2, 6'd0, 5'd0, Q_SIXTY_FOUR);
    send_request(OP_LOAD_ELEM, 7'd2, 6'd1, 5'd0, Q_MIN);
    write_reg(REG_BOND_COUNT, 32'd2);
    compute_row(7'd0);
    write_reg(REG_BOND_COUNT, 32'd3);
    compute_row(7'd1);
  endtask

  // Zero and one atom, zero bonds, counts past the bounds
  task automatic test_count_extremes();
    write_reg(REG_ATOM_COUNT, 32'd0);
    compute_row(7'd0);
    write_reg(REG_ATOM_COUNT, 32'd1);
    write_reg(REG_BOND_COUNT, 32'd0);
    compute_row(7'd0);
    // atom count past the bound with no bonds: a full row of zeros, few loads
    write_reg(REG_ATOM_COUNT, 32'hFFFF_FF7F);
    compute_row(7'd63);
    compute_row(7'd0);
    compute_row(7'd100);
    write_reg(REG_BOND_COUNT, 32'hFFFF_FFFF);
  endtask

  // Phases of random requests, each under freshly drawn counts
  task automatic test_random_traffic();
    int n, nb;
    logic [6:0] row;
    for (int phase = 0; phase < 5; phase++) begin
      // wide atom counts only without bonds, so that fills stay small
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(0, 127);
        nb = 0;
      end else begin
        n = $urandom_range(1, 4);
        nb = $urandom_range(0, 4);
      end
      write_reg(REG_ATOM_COUNT, ($urandom() & ~32'h7F) | 32'(n));
      write_reg(REG_BOND_COUNT, ($urandom() & ~32'hFF) | 32'(nb));
      if ($urandom_range(0, 2) == 0) send_burst = 20;
      for (int i = 0; i < 12; i++) begin
        n = used_atoms();
        nb = used_bonds();
        case ($urandom_range(0, 9))
          0, 1: begin
            row = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(32, 127))
                                               : 7'($urandom_range(0, 31));
            send_request(OP_LOAD_HARD, row, 6'($urandom()), 5'($urandom()), draw_q());
          end
          2: send_request(OP_LOAD_TYPE, 7'(pick_index(nb, 127)), 6'($urandom()),
                          5'($urandom()), $urandom());
          3, 4, 5: send_request(OP_LOAD_ELEM, 7'(pick_index(nb, 127)),
                                6'(pick_index(n, 63)), 5'($urandom()), draw_q());
          default: compute_row(7'(pick_index(n, 127)));
        endcase
      end
    end
  endtask

  // Result side: random stalls per result, with stretches of none
  initial begin : ready_driver
    int gap;
    forever begin
      if (ready_burst > 0) begin
        gap = 0;
        ready_burst--;
      end else begin
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 30) == 0) ready_burst = $urandom_range(10, 40);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
    end
  end

  // Compare each taken result with the oldest expected element
  always @(posedge clk) begin : result_check
    gram_elem_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (expected_elems.size() == 0) begin
        report_mismatch($sformatf("unexpected result row %0d col %0d",
                                  m_tdata[5:0], m_tdata[11:6]));
      end else begin
        want = expected_elems.pop_front();
        if (m_tdata[5:0] !== want.row)
          report_mismatch($sformatf("row %0d, expected %0d", m_tdata[5:0], want.row));
        if (m_tdata[11:6] !== want.col)
          report_mismatch($sformatf("row %0d column %0d, expected %0d",
                                    want.row, m_tdata[11:6], want.col));
        if (m_tdata[43:12] !== want.value)
          report_mismatch($sformatf("H[%0d][%0d] = %h, expected %h",
                                    want.row, want.col, m_tdata[43:12], want.value));
        if (m_tuser !== want.sat)
          report_mismatch($sformatf("H[%0d][%0d] saturated %b, expected %b",
                                    want.row, want.col, m_tuser, want.sat));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("H[%0d][%0d] last %b, expected %b",
                                    want.row, want.col, m_tlast, want.last));
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_loads_at_reset();
    test_clipping();
    test_count_extremes();
    test_random_traffic();
    settle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/wgm_pkg.sv
hw/rtl/wgm_datapath.sv
hw/rtl/wgm_ctrl.sv
hw/rtl/weighted_gram_matrix_engine.sv
bench/weighted_gram_matrix_engine_tb.sv
